// ===== rtl/bhgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bhgc_pkg
// shared types and constants for the button hold gesture classifier
// ----------------------------------------------------------------------------
package bhgc_pkg;

   localparam int HELD_W  = 17;
   localparam int HOLD_W  = 16;
   localparam int DT_W    = 16;
   localparam int PCT_W   = 7;
   localparam int ACC_W   = 24;
   localparam int STEP_W  = 3;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [HELD_W-1:0] HELD_MAX         = '1;
   localparam logic [HOLD_W-1:0] SHORT_HOLD_RESET = 16'd1000;
   localparam logic [HOLD_W-1:0] RESET_HOLD_RESET = 16'd5000;
   localparam logic [PCT_W-1:0]  PCT_FULL         = 7'd100;
   localparam logic [STEP_W-1:0] DIV_TOP_STEP     = 3'd6;

   localparam logic CMD_BEGIN  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic REG_SHORT_HOLD = 1'b0;
   localparam logic REG_RESET_HOLD = 1'b1;

   typedef enum logic [1:0] {
      GESTURE_NONE  = 2'd0,
      GESTURE_TAP   = 2'd1,
      GESTURE_SHORT = 2'd2,
      GESTURE_RESET = 2'd3
   } gesture_type;

   typedef struct packed {
      logic [HOLD_W-1:0] short_hold_time;
      logic [HOLD_W-1:0] reset_hold_time;
   } cfg_type;

   typedef struct packed {
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [ACC_W-1:0] sum;
      logic             carry;
   } alu_rsp_type;

endpackage

// ===== rtl/bhgc_if.sv =====
// ----------------------------------------------------------------------------
// bhgc channel interfaces
// sample/command word in, classification word out
// ----------------------------------------------------------------------------
interface bhgc_req_if;
   import bhgc_pkg::*;

   logic            valid;
   logic            ready;
   logic            cmd;
   logic            pressed;
   logic [DT_W-1:0] elapsed_ms;

   modport source (output valid, output cmd, output pressed, output elapsed_ms, input ready);
   modport sink   (input valid, input cmd, input pressed, input elapsed_ms, output ready);
endinterface

interface bhgc_rsp_if;
   import bhgc_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       gesture;
   logic [PCT_W-1:0] progress_pct;
   logic             short_reached;

   modport source (output valid, output gesture, output progress_pct, output short_reached,
                   input ready);
   modport sink   (input valid, input gesture, input progress_pct, input short_reached,
                   output ready);
endinterface

// ===== rtl/button_hold_gesture_classifier_core.sv =====
// ----------------------------------------------------------------------------
// button_hold_gesture_classifier_core
// long-press classifier: tap, short hold or reset from timed button samples
// ----------------------------------------------------------------------------
// A begin word (cmd 0) opens a session; each sample word (cmd 1) adds its
// elapsed_ms to the held time while the button is down. Reaching the reset
// threshold while held reports reset at once, reaching the short threshold
// latches a short hold that the release reports, and an early release is a
// tap. Every input word yields exactly one result word carrying the gesture,
// the hold progress as a percentage of the reset threshold (capped at 100)
// and the latched short-hold flag. A single shared add/subtract unit does
// the held-time update, both threshold compares, the times-100 product and
// a seven-step restoring divide; a capped progress skips the product and the
// divide. The input is taken only while the sequencer is idle, but a
// finished result may still wait in the output register while the next word
// is accepted. Thresholds are written through the csr port (short hold at
// 0x0, reset hold at 0x4); the user must write them only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module button_hold_gesture_classifier_core (
   input  logic                        clock,
   input  logic                        reset,
   bhgc_req_if.sink                    req_chan,
   bhgc_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bhgc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bhgc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [bhgc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import bhgc_pkg::*;

   // thresholds, straight from the register block
   cfg_type     cfg;
   // shared unit operands and result
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   bhgc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // one adder/subtractor, time-shared by the sequencer
   bhgc_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // session state, sequencer and output word register
   bhgc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .alu_req  (alu_req),
      .alu_rsp  (alu_rsp),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );
endmodule

// ===== rtl/bhgc_alu.sv =====
// ----------------------------------------------------------------------------
// bhgc_alu
// shared add/subtract unit, carry out doubles as the a >= b flag
// ----------------------------------------------------------------------------
module bhgc_alu (
   input  bhgc_pkg::alu_req_type req,
   output bhgc_pkg::alu_rsp_type rsp
);
   import bhgc_pkg::*;

   logic [ACC_W:0] total;

   assign total = {1'b0, req.a} + {1'b0, req.b ^ {ACC_W{req.sub}}} + {{ACC_W{1'b0}}, req.sub};

   assign rsp.sum   = total[ACC_W-1:0];
   assign rsp.carry = total[ACC_W];
endmodule

// ===== rtl/bhgc_regs.sv =====
// ----------------------------------------------------------------------------
// bhgc_regs
// threshold registers behind the apb-style port
// ----------------------------------------------------------------------------
module bhgc_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [bhgc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bhgc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [bhgc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                      csr_pready,
   output bhgc_pkg::cfg_type         cfg
);
   import bhgc_pkg::*;

   logic [HOLD_W-1:0] short_ff, short_in;
   logic [HOLD_W-1:0] reset_hold_ff, reset_hold_in;
   logic              wr_en;
   logic              reg_sel;

   assign reg_sel = csr_paddr[2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      short_in      = short_ff;
      reset_hold_in = reset_hold_ff;
      if (wr_en) begin
         if (reg_sel == REG_SHORT_HOLD) short_in = csr_pwdata[HOLD_W-1:0];
         else                           reset_hold_in = csr_pwdata[HOLD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff      <= SHORT_HOLD_RESET;
         reset_hold_ff <= RESET_HOLD_RESET;
      end else begin
         short_ff      <= short_in;
         reset_hold_ff <= reset_hold_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (reg_sel == REG_SHORT_HOLD) ?
                       {{(CSR_DW-HOLD_W){1'b0}}, short_ff} :
                       {{(CSR_DW-HOLD_W){1'b0}}, reset_hold_ff};

   assign cfg.short_hold_time = short_ff;
   assign cfg.reset_hold_time = reset_hold_ff;
endmodule

// ===== rtl/bhgc_seq.sv =====
// ----------------------------------------------------------------------------
// bhgc_seq
// session state and the sequencer that drives the shared alu
// ----------------------------------------------------------------------------
module bhgc_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  bhgc_pkg::cfg_type     cfg,
   output bhgc_pkg::alu_req_type alu_req,
   input  bhgc_pkg::alu_rsp_type alu_rsp,
   bhgc_req_if.sink              req_chan,
   bhgc_rsp_if.source            rsp_chan
);
   import bhgc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ADD, S_CMP_RST, S_CMP_SHORT, S_CAP, S_MUL1, S_MUL2, S_DIV, S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic              decided_ff, decided_in;
   logic              fired_ff, fired_in;
   logic              pending_ff, pending_in;
   logic              pressed_ff, pressed_in;
   logic [DT_W-1:0]   dt_ff, dt_in;
   gesture_type       gesture_ff, gesture_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PCT_W-1:0]  quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   gesture_type       rsp_gesture_ff, rsp_gesture_in;
   logic [PCT_W-1:0]  rsp_pct_ff, rsp_pct_in;
   logic              rsp_short_ff, rsp_short_in;

   logic [ACC_W-1:0] held_x;
   logic [ACC_W-1:0] rst_x;
   logic             accept;

   assign held_x = {{(ACC_W-HELD_W){1'b0}}, held_ff};
   assign rst_x  = {{(ACC_W-HOLD_W){1'b0}}, cfg.reset_hold_time};
   assign accept = req_chan.valid & req_chan.ready;

   always_comb begin
      state_in       = state_ff;
      held_in        = held_ff;
      decided_in     = decided_ff;
      fired_in       = fired_ff;
      pending_in     = pending_ff;
      pressed_in     = pressed_ff;
      dt_in          = dt_ff;
      gesture_in     = gesture_ff;
      acc_in         = acc_ff;
      quot_in        = quot_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      rsp_gesture_in = rsp_gesture_ff;
      rsp_pct_in     = rsp_pct_ff;
      rsp_short_in   = rsp_short_ff;
      alu_req.a      = held_x;
      alu_req.b      = rst_x;
      alu_req.sub    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pressed_in = req_chan.pressed;
               dt_in      = req_chan.elapsed_ms;
               gesture_in = GESTURE_NONE;
               if (req_chan.cmd == CMD_BEGIN) begin
                  held_in    = '0;
                  decided_in = 1'b0;
                  fired_in   = 1'b0;
                  pending_in = 1'b0;
                  state_in   = S_CAP;
               end else if (decided_ff) begin
                  state_in = S_CAP;
               end else if (req_chan.pressed) begin
                  state_in = S_ADD;
               end else begin
                  decided_in = 1'b1;
                  state_in   = S_CMP_SHORT;
               end
            end
         end
         S_ADD: begin
            alu_req.b   = {{(ACC_W-DT_W){1'b0}}, dt_ff};
            alu_req.sub = 1'b0;
            held_in     = alu_rsp.sum[HELD_W] ? HELD_MAX : alu_rsp.sum[HELD_W-1:0];
            state_in    = S_CMP_RST;
         end
         S_CMP_RST: begin
            if (alu_rsp.carry) begin
               decided_in = 1'b1;
               gesture_in = GESTURE_RESET;
               state_in   = S_CAP;
            end else begin
               state_in = S_CMP_SHORT;
            end
         end
         S_CMP_SHORT: begin
            alu_req.b = {{(ACC_W-HOLD_W){1'b0}}, cfg.short_hold_time};
            if (pressed_ff) begin
               if (!fired_ff && alu_rsp.carry) begin
                  fired_in   = 1'b1;
                  pending_in = 1'b1;
               end
            end else if (fired_ff || alu_rsp.carry) begin
               gesture_in = pending_ff ? GESTURE_SHORT : GESTURE_NONE;
            end else begin
               gesture_in = GESTURE_TAP;
            end
            state_in = S_CAP;
         end
         S_CAP: begin
            // held at or past the reset threshold (or a zero threshold) caps at full
            if (alu_rsp.carry) begin
               quot_in  = PCT_FULL;
               state_in = S_OUT;
            end else begin
               quot_in  = '0;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            // held * 100 as held*64 + held*32 + held*4
            alu_req.a   = held_x << 6;
            alu_req.b   = held_x << 5;
            alu_req.sub = 1'b0;
            acc_in      = alu_rsp.sum;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            alu_req.a   = acc_ff;
            alu_req.b   = held_x << 2;
            alu_req.sub = 1'b0;
            acc_in      = alu_rsp.sum;
            step_in     = DIV_TOP_STEP;
            state_in    = S_DIV;
         end
         S_DIV: begin
            alu_req.a = acc_ff;
            alu_req.b = rst_x << step_ff;
            if (alu_rsp.carry) begin
               acc_in           = alu_rsp.sum;
               quot_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) state_in = S_OUT;
            else               step_in  = step_ff - 1'b1;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_gesture_in = gesture_ff;
               rsp_pct_in     = quot_ff;
               rsp_short_in   = fired_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pressed_ff     <= pressed_in;
      dt_ff          <= dt_in;
      gesture_ff     <= gesture_in;
      acc_ff         <= acc_in;
      quot_ff        <= quot_in;
      step_ff        <= step_in;
      rsp_gesture_ff <= rsp_gesture_in;
      rsp_pct_ff     <= rsp_pct_in;
      rsp_short_ff   <= rsp_short_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         decided_ff   <= 1'b0;
         fired_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         decided_ff   <= decided_in;
         fired_ff     <= fired_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.gesture       = rsp_gesture_ff;
   assign rsp_chan.progress_pct  = rsp_pct_ff;
   assign rsp_chan.short_reached = rsp_short_ff;
endmodule
